[design/best_fit_hole_allocator_core_assert.svh]
// assertion macros for the allocator core
`ifndef BEST_FIT_HOLE_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_HOLE_ALLOCATOR_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define BFH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BFH_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[design/bfha_pkg.sv]
package bfha_pkg;

	localparam int unsigned OP_W = 2;
	localparam int unsigned SIZE_W = 17;
	localparam int unsigned START_W = 16;
	localparam int unsigned COUNT_W = 6;

	typedef enum logic [OP_W-1:0] {
		OP_FREE    = 2'd0,
		OP_RESERVE = 2'd1,
		OP_PROBE   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SIZE_W-1:0]  req_size;
		logic [START_W-1:0] range_start;
		logic [SIZE_W-1:0]  range_end;
	} req_t;

	typedef struct packed {
		logic               fits;
		logic [START_W-1:0] block_start;
		logic [SIZE_W-1:0]  block_end;
		logic [SIZE_W-1:0]  free_total;
		logic [COUNT_W-1:0] hole_count;
		logic               table_full;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_WRITE2,
		ST_DONE
	} state_t;

endpackage

[design/best_fit_hole_allocator_core.sv]
// best-fit hole allocator with coalescing
// channels: a request transaction (req) is taken when start is high and busy
// is low; op selects free (0), reserve (1), probe (2); op 3 does nothing
// the result transaction appears on rsp for one cycle with done high; the
// receiver cannot stall, so there is no back pressure on the result side
// after the accepting edge the core passes through the scan state, one entry
// read per cycle through a single synchronous read port, then the drain,
// write-back and spare states and the result state, in which done is high
// busy stays high from acceptance through the done cycle, so the next request
// is taken no earlier than the cycle after done
// a free merges with a hole ending at its start and one starting at its end;
// a reserve takes the smallest fitting hole (higher start wins ties) and
// carves the block from its top end; every result carries the free total
// and hole count after the operation
// reset clears every valid bit, the total and the count at once; the table
// contents need no clearing pass since an entry is used only when valid
module best_fit_hole_allocator_core #(
	parameter int unsigned MAX_HOLES = 32,
	parameter int unsigned ADDR_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bfha_pkg::req_t req,
	output logic           done,
	output bfha_pkg::rsp_t rsp
);
	import bfha_pkg::*;

	localparam int unsigned IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_HOLES + 1);
	localparam int unsigned AW = ADDR_BITS;
	localparam int unsigned EW = ADDR_BITS + 1;
	localparam logic [EW-1:0] SPACE = EW'(1) << ADDR_BITS;

	// hole table
	logic [AW-1:0] first_mem [MAX_HOLES];
	logic [EW-1:0] limit_mem [MAX_HOLES];
	logic [MAX_HOLES-1:0] valid_q;
	logic [EW-1:0] total_q;
	logic [CNT_W-1:0] held_q;

	state_t state_q, state_d;
	req_t req_q;
	logic [IDX_W:0] rd_cnt_q;
	logic [IDX_W-1:0] rd_idx_s1;
	logic rd_vld_s1;
	logic [AW-1:0] rd_first_s1;
	logic [EW-1:0] rd_limit_s1;

	logic best_ok_q, upper_ok_q, lower_ok_q, slot_ok_q;
	logic [IDX_W-1:0] best_idx_q, upper_idx_q, lower_idx_q, slot_idx_q;
	logic [EW-1:0] best_size_q, best_limit_q;
	logic [AW-1:0] best_first_q, lower_first_q;
	logic full_q, fits_q;
	logic [AW-1:0] bs_q;
	logic [EW-1:0] be_q;

	logic [EW-1:0] req_e, req_sz;
	logic [AW-1:0] req_s;
	logic free_ok;
	assign req_e = req_q.range_end[EW-1:0];
	assign req_s = req_q.range_start[AW-1:0];
	assign req_sz = req_q.req_size[EW-1:0];
	assign free_ok = (req_e > EW'(req_s)) && (req_e <= SPACE);

	logic scan_last;
	assign scan_last = (rd_cnt_q == (IDX_W+1)'(MAX_HOLES));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_SCAN;
			ST_SCAN:   if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_WRITE2;
			ST_WRITE2: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		rsp.fits = fits_q;
		rsp.block_start = START_W'(bs_q);
		rsp.block_end = SIZE_W'(be_q);
		rsp.free_total = SIZE_W'(total_q);
		rsp.hole_count = COUNT_W'(held_q);
		rsp.table_full = full_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// read port: one entry per scan cycle, none in the last scan cycle
	logic rd_en;
	assign rd_en = (state_q == ST_SCAN) && !scan_last;
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_first_s1 <= first_mem[rd_cnt_q[IDX_W-1:0]];
			rd_limit_s1 <= limit_mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (state_q == ST_IDLE) rd_cnt_q <= '0;
			else if (rd_en) rd_cnt_q <= rd_cnt_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (rd_en) rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
	end

	// per-entry evaluation against the running choice
	logic ent_valid;
	logic [EW-1:0] ent_size;
	logic ent_fit, ent_better;
	assign ent_valid = valid_q[rd_idx_s1];
	assign ent_size = rd_limit_s1 - EW'(rd_first_s1);
	assign ent_fit = ent_valid && (ent_size >= req_sz);
	assign ent_better = !best_ok_q || (ent_size < best_size_q) ||
		((ent_size == best_size_q) && (rd_first_s1 > best_first_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_ok_q <= 1'b0;
			upper_ok_q <= 1'b0;
			lower_ok_q <= 1'b0;
			slot_ok_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			best_ok_q <= 1'b0;
			upper_ok_q <= 1'b0;
			lower_ok_q <= 1'b0;
			slot_ok_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (ent_fit && ent_better) best_ok_q <= 1'b1;
			if (!ent_valid && !slot_ok_q) slot_ok_q <= 1'b1;
			if (ent_valid && !upper_ok_q && (EW'(rd_first_s1) == req_e))
				upper_ok_q <= 1'b1;
			if (ent_valid && !lower_ok_q && (rd_limit_s1 == EW'(req_s)) &&
				!(!upper_ok_q && (EW'(rd_first_s1) == req_e)))
				lower_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (ent_fit && ent_better) begin
				best_idx_q <= rd_idx_s1;
				best_size_q <= ent_size;
				best_first_q <= rd_first_s1;
				best_limit_q <= rd_limit_s1;
			end
			if (!ent_valid && !slot_ok_q) slot_idx_q <= rd_idx_s1;
			if (ent_valid && !upper_ok_q && (EW'(rd_first_s1) == req_e))
				upper_idx_q <= rd_idx_s1;
			if (ent_valid && !lower_ok_q && (rd_limit_s1 == EW'(req_s)) &&
				!(!upper_ok_q && (EW'(rd_first_s1) == req_e))) begin
				lower_idx_q <= rd_idx_s1;
				lower_first_q <= rd_first_s1;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= req;
	end

	// write-back: every table write in ST_WRITE, ST_WRITE2 is a spare cycle
	logic [EW-1:0] carve_limit;
	logic [EW:0] total_add;
	op_t op_q;
	assign op_q = op_t'(req_q.op);
	assign carve_limit = best_limit_q - req_sz;
	assign total_add = {1'b0, total_q} + {1'b0, req_e - EW'(req_s)};

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			case (op_q)
				OP_FREE: begin
					if (free_ok) begin
						if (upper_ok_q && lower_ok_q)
							first_mem[upper_idx_q] <= lower_first_q;
						else if (upper_ok_q)
							first_mem[upper_idx_q] <= req_s;
						else if (lower_ok_q)
							limit_mem[lower_idx_q] <= req_e;
						else if (slot_ok_q) begin
							first_mem[slot_idx_q] <= req_s;
							limit_mem[slot_idx_q] <= req_e;
						end
					end
				end
				OP_RESERVE: if (best_ok_q) limit_mem[best_idx_q] <= carve_limit;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			held_q <= '0;
			fits_q <= 1'b0;
			full_q <= 1'b0;
			bs_q <= '0;
			be_q <= '0;
		end else if (state_q == ST_WRITE) begin
			fits_q <= 1'b0;
			full_q <= 1'b0;
			bs_q <= '0;
			be_q <= '0;
			case (op_q)
				OP_FREE: begin
					if (free_ok) begin
						if (!upper_ok_q && !lower_ok_q && !slot_ok_q) begin
							full_q <= 1'b1;
						end else begin
							if (upper_ok_q && lower_ok_q) begin
								valid_q[lower_idx_q] <= 1'b0;
								if (held_q != '0) held_q <= held_q - 1'b1;
							end else if (!upper_ok_q && !lower_ok_q) begin
								valid_q[slot_idx_q] <= 1'b1;
								held_q <= held_q + 1'b1;
							end
							total_q <= (total_add > {1'b0, SPACE}) ? SPACE :
								total_add[EW-1:0];
						end
					end
				end
				OP_RESERVE: begin
					if (best_ok_q) begin
						fits_q <= 1'b1;
						be_q <= best_limit_q;
						bs_q <= carve_limit[AW-1:0];
						total_q <= (total_q >= req_sz) ? total_q - req_sz : '0;
						if (carve_limit == EW'(best_first_q)) begin
							valid_q[best_idx_q] <= 1'b0;
							if (held_q != '0) held_q <= held_q - 1'b1;
						end
					end
				end
				OP_PROBE: fits_q <= best_ok_q;
				default: ;
			endcase
		end
	end

	`include "best_fit_hole_allocator_core_assert.svh"

	`BFH_ASSERT(a_done_one_cycle, done |-> (state_q == ST_DONE) && busy, "done outside result cycle")
	`BFH_ASSERT_NEXT(a_done_then_idle, done, !busy, "busy after result")
	`BFH_ASSERT(a_held_bound, held_q <= CNT_W'(MAX_HOLES), "hole count over table size")
	`BFH_ASSERT(a_total_bound, total_q <= SPACE, "free total over address space")

endmodule

[tb/best_fit_hole_allocator_core_tb.sv]
`timescale 1ns / 1ps

module best_fit_hole_allocator_core_tb;
	import bfha_pkg::*;

	localparam int HOLES = 32;
	localparam int SPACE = 65536;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	int sender_idle_pct;

	best_fit_hole_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// allocator prediction and result checking
	class alloc_scoreboard;
		bit [15:0] first_q[HOLES];
		bit [16:0] limit_q[HOLES];
		bit        valid_q[HOLES];
		bit [16:0] total;
		bit [5:0]  held;
		rsp_t      pending[$];
		int        mismatches;

		function new();
			for (int i = 0; i < HOLES; i++) begin
				valid_q[i] = 0;
				first_q[i] = '0;
				limit_q[i] = '0;
			end
			total = '0;
			held = '0;
			mismatches = 0;
		endfunction

		// smallest hole of at least sz, higher start on ties
		function int best_hole(bit [16:0] sz);
			int best;
			bit [16:0] best_sz;
			bit [16:0] hs;
			best = -1;
			best_sz = '0;
			for (int i = 0; i < HOLES; i++) begin
				if (!valid_q[i])
					continue;
				hs = limit_q[i] - first_q[i];
				if (hs < sz)
					continue;
				if (best < 0 || hs < best_sz ||
						(hs == best_sz && first_q[i] > first_q[best])) begin
					best = i;
					best_sz = hs;
				end
			end
			return best;
		endfunction

		// returns 1 when the range was dropped for a full table
		function bit release_range(bit [15:0] s, bit [16:0] e);
			int up;
			int lo;
			int slot;
			int sum;
			up = -1;
			lo = -1;
			slot = -1;
			if (e <= {1'b0, s} || e > SPACE)
				return 0;
			for (int i = 0; i < HOLES; i++) begin
				if (!valid_q[i]) begin
					if (slot < 0)
						slot = i;
					continue;
				end
				if (up < 0 && {1'b0, first_q[i]} == e)
					up = i;
				if (lo < 0 && limit_q[i] == {1'b0, s} && i != up)
					lo = i;
			end
			if (up < 0 && lo < 0) begin
				if (slot < 0)
					return 1;
				valid_q[slot] = 1;
				first_q[slot] = s;
				limit_q[slot] = e;
				held++;
			end else if (up >= 0 && lo >= 0) begin
				first_q[up] = first_q[lo];
				valid_q[lo] = 0;
				first_q[lo] = '0;
				limit_q[lo] = '0;
				if (held > 0)
					held--;
			end else if (up >= 0) begin
				first_q[up] = s;
			end else begin
				limit_q[lo] = e;
			end
			sum = int'(total) + int'(e) - int'(s);
			total = (sum > SPACE) ? 17'(SPACE) : 17'(sum);
			return 0;
		endfunction

		// accepted request transaction
		function void note_request(req_t r);
			rsp_t x;
			int k;
			x = '0;
			case (op_t'(r.op))
				OP_FREE: x.table_full = release_range(r.range_start, r.range_end);
				OP_RESERVE: begin
					k = best_hole(r.req_size);
					if (k >= 0) begin
						x.fits = 1;
						x.block_end = limit_q[k];
						limit_q[k] = limit_q[k] - r.req_size;
						x.block_start = limit_q[k][15:0];
						total = (total >= r.req_size) ? total - r.req_size : '0;
						if (limit_q[k] == {1'b0, first_q[k]}) begin
							valid_q[k] = 0;
							first_q[k] = '0;
							limit_q[k] = '0;
							if (held > 0)
								held--;
						end
					end
				end
				OP_PROBE: x.fits = (best_hole(r.req_size) >= 0);
				default: ;
			endcase
			x.free_total = total;
			x.hole_count = held;
			pending.push_back(x);
		endfunction

		// result transaction against the oldest expectation
		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.fits !== want.fits || got.block_start !== want.block_start ||
					got.block_end !== want.block_end ||
					got.free_total !== want.free_total ||
					got.hole_count !== want.hole_count ||
					got.table_full !== want.table_full) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p", want, got);
			end
		endfunction
	endclass

	alloc_scoreboard sb;

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	// request monitor
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_request(req);
	end

	// one request transaction, with a random idle gap before it
	task automatic send(op_t op, int sz, int s, int e);
		while ($urandom_range(99) < sender_idle_pct)
			@(negedge clk);
		req.op = op;
		req.req_size = 17'(sz);
		req.range_start = 16'(s);
		req.range_end = 17'(e);
		start = 1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 10000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	// random request: frees (some of aligned chunks), reserves, probes and no-ops
	task automatic random_request();
		int pick;
		int s;
		int e;
		pick = $urandom_range(99);
		s = $urandom_range(0, 65535);
		if (pick < 40) begin
			if ($urandom_range(3) == 0)
				s = $urandom_range(0, 255) * 256;
			e = s + (($urandom_range(3) == 0) ? $urandom_range(1, 65536) :
				$urandom_range(1, 600));
			if (e > SPACE && $urandom_range(1) == 0)
				e = SPACE;
			if ($urandom_range(19) == 0)
				e = $urandom_range(1, 131071);
			send(OP_FREE, $urandom_range(0, 131071), s, e);
		end else if (pick < 75) begin
			send(OP_RESERVE, ($urandom_range(9) == 0) ?
				$urandom_range(0, 131071) : $urandom_range(0, 700), s,
				$urandom_range(0, 131071));
		end else if (pick < 95) begin
			send(OP_PROBE, ($urandom_range(4) == 0) ?
				$urandom_range(0, 131071) : $urandom_range(0, 2000), s,
				$urandom_range(0, 131071));
		end else begin
			send(OP_NONE, $urandom_range(0, 131071), s, $urandom_range(0, 131071));
		end
	endtask

	// stimulus
	initial begin
		sb = new();
		sender_idle_pct = 0;
		start = 0;
		req = '0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, merges, extremes, edge cases
		send(OP_RESERVE, 1, 0, 0);
		send(OP_PROBE, 0, 0, 0);
		send(OP_FREE, 0, 100, 100);
		send(OP_FREE, 0, 200, 100);
		send(OP_FREE, 0, 65535, 65537);
		send(OP_FREE, 0, 100, 200);
		send(OP_FREE, 0, 300, 400);
		send(OP_FREE, 0, 200, 300);
		send(OP_FREE, 0, 0, 50);
		send(OP_FREE, 0, 65535, 65536);
		send(OP_PROBE, 300, 0, 0);
		send(OP_PROBE, 301, 0, 0);
		send(OP_RESERVE, 0, 0, 0);
		send(OP_RESERVE, 1, 0, 0);
		send(OP_RESERVE, 50, 0, 0);
		send(OP_RESERVE, 131071, 0, 0);
		send(OP_FREE, 0, 150, 160);
		send(OP_RESERVE, 100, 0, 0);
		send(OP_NONE, 131071, 65535, 131071);
		send(OP_RESERVE, 200, 0, 0);
		send(OP_FREE, 0, 0, 65536);
		send(OP_PROBE, 65536, 0, 0);
		send(OP_RESERVE, 65536, 0, 0);
		drain();

		// fill the table to overflow
		for (int i = 0; i < 34; i++)
			send(OP_FREE, 0, i * 4, i * 4 + 2);
		send(OP_FREE, 0, 2, 4);
		for (int i = 0; i < 34; i++)
			send(OP_RESERVE, $urandom_range(0, 3), 0, 0);

		// random phases
		sender_idle_pct = 10;
		for (int i = 0; i < 160; i++)
			random_request();
		drain();
		sender_idle_pct = 54;
		for (int i = 0; i < 160; i++)
			random_request();
		sender_idle_pct = 0;
		for (int i = 0; i < 140; i++)
			random_request();

		drain();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[best_fit_hole_allocator_core] OK");
		else
			$display("[best_fit_hole_allocator_core] ERROR");
		$finish;
	end

	// timeout
	initial begin
		#5000000;
		$display("[best_fit_hole_allocator_core] ERROR");
		$finish;
	end

endmodule
